// ===== rtl/rc4_pkg.sv =====
package rc4_pkg;

  localparam int MAX_KEY_BYTES = 16;
  localparam int KEY_SLOTS     = 16;
  localparam int TABLE_SIZE    = 256;
  localparam int BYTE_W        = 8;
  localparam int TABLE_AW      = $clog2(TABLE_SIZE);
  localparam int KEY_W         = 64;
  localparam int LEN_W         = 5;
  localparam int KPOS_W        = $clog2(KEY_SLOTS);
  localparam int CFG_IDX_W     = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY_LOW,
    CFG_KEY_HIGH,
    CFG_KEY_LENGTH
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FILL,
    ST_K0,
    ST_K1,
    ST_K2,
    ST_K3,
    ST_G0,
    ST_G1,
    ST_G2,
    ST_G3
  } state_t;

  typedef struct packed {
    logic [KEY_W-1:0] key_low;
    logic [KEY_W-1:0] key_high;
    logic [LEN_W-1:0] key_length;
  } key_cfg_t;

endpackage

// ===== rtl/rc4_if.sv =====
interface rc4_in_if;
  logic                      valid;
  logic                      ready;
  logic [rc4_pkg::BYTE_W-1:0] data_in;
  logic                      start_req;

  modport source (output valid, output data_in, output start_req, input ready);
  modport sink   (input valid, input data_in, input start_req, output ready);
endinterface

interface rc4_out_if;
  logic                      valid;
  logic                      ready;
  logic [rc4_pkg::BYTE_W-1:0] data_out;

  modport source (output valid, output data_out, input ready);
  modport sink   (input valid, input data_out, output ready);
endinterface

// ===== rtl/rc4_ram.sv =====
module rc4_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/rc4_core.sv =====
module rc4_core (
  input  logic                clk,
  input  logic                rst_n,
  input  rc4_pkg::key_cfg_t   key_cfg,
  rc4_in_if.sink              in_ch,
  rc4_out_if.source           out_ch
);

  localparam int BW = rc4_pkg::BYTE_W;

  rc4_pkg::state_t state_r, state_nxt;

  logic [BW-1:0] cnt_r, cnt_nxt;
  logic [BW-1:0] acc_r, acc_nxt;
  logic [rc4_pkg::KPOS_W-1:0] kpos_r, kpos_nxt;
  logic [BW-1:0] i_r, i_nxt;
  logic [BW-1:0] j_r, j_nxt;
  logic [BW-1:0] si_r, si_nxt;
  logic [BW-1:0] sj_r, sj_nxt;
  logic [BW-1:0] here_r, here_nxt;
  logic [BW-1:0] t_r, t_nxt;
  logic [BW-1:0] data_r, data_nxt;
  logic          sched_r, sched_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [BW-1:0] out_data_r, out_data_nxt;

  logic                       ram_we;
  logic [rc4_pkg::TABLE_AW-1:0] ram_waddr;
  logic [BW-1:0]              ram_wdata;
  logic [rc4_pkg::TABLE_AW-1:0] ram_raddr;
  logic [BW-1:0]              ram_rdata;

  logic accept;
  logic need_sched;
  logic out_free;
  logic last_cnt;
  logic [rc4_pkg::KEY_SLOTS-1:0][BW-1:0] key_bytes;
  logic [BW-1:0] key_byte;
  logic [rc4_pkg::LEN_W-1:0] key_len;
  logic [rc4_pkg::LEN_W-1:0] kpos_inc;
  logic [BW-1:0] i_inc;
  logic [BW-1:0] acc_sum;
  logic [BW-1:0] j_sum;
  logic [BW-1:0] t_sum;
  logic [BW-1:0] ks_byte;

  assign in_ch.ready     = (state_r == rc4_pkg::ST_IDLE);
  assign accept          = in_ch.valid && in_ch.ready;
  assign need_sched      = in_ch.start_req || !sched_r;
  assign out_free        = !out_valid_r || out_ch.ready;
  assign out_ch.valid    = out_valid_r;
  assign out_ch.data_out = out_data_r;
  assign last_cnt        = (cnt_r == BW'(rc4_pkg::TABLE_SIZE - 1));

  assign key_bytes = {key_cfg.key_high, key_cfg.key_low};
  assign key_byte  = key_bytes[kpos_r];
  assign kpos_inc  = {1'b0, kpos_r} + rc4_pkg::LEN_W'(1);
  assign i_inc     = i_r + BW'(1);
  assign acc_sum   = acc_r + ram_rdata + key_byte;
  assign j_sum     = j_r + ram_rdata;
  assign t_sum     = si_r + ram_rdata;

  always_comb begin
    if (key_cfg.key_length == '0) begin
      key_len = rc4_pkg::LEN_W'(1);
    end else if (key_cfg.key_length > rc4_pkg::LEN_W'(rc4_pkg::MAX_KEY_BYTES)) begin
      key_len = rc4_pkg::LEN_W'(rc4_pkg::MAX_KEY_BYTES);
    end else begin
      key_len = key_cfg.key_length;
    end
  end

  // keystream byte after the swap
  always_comb begin
    if (t_r == j_r) begin
      ks_byte = si_r;
    end else if (t_r == i_r) begin
      ks_byte = sj_r;
    end else begin
      ks_byte = ram_rdata;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rc4_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = need_sched ? rc4_pkg::ST_FILL : rc4_pkg::ST_G1;
        end
      end
      rc4_pkg::ST_FILL: begin
        if (last_cnt) begin
          state_nxt = rc4_pkg::ST_K0;
        end
      end
      rc4_pkg::ST_K0: state_nxt = rc4_pkg::ST_K1;
      rc4_pkg::ST_K1: state_nxt = rc4_pkg::ST_K2;
      rc4_pkg::ST_K2: state_nxt = rc4_pkg::ST_K3;
      rc4_pkg::ST_K3: state_nxt = last_cnt ? rc4_pkg::ST_G0 : rc4_pkg::ST_K0;
      rc4_pkg::ST_G0: state_nxt = rc4_pkg::ST_G1;
      rc4_pkg::ST_G1: state_nxt = rc4_pkg::ST_G2;
      rc4_pkg::ST_G2: state_nxt = rc4_pkg::ST_G3;
      rc4_pkg::ST_G3: begin
        if (out_free) begin
          state_nxt = rc4_pkg::ST_IDLE;
        end
      end
      default: state_nxt = rc4_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cnt_nxt       = cnt_r;
    acc_nxt       = acc_r;
    kpos_nxt      = kpos_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    si_nxt        = si_r;
    sj_nxt        = sj_r;
    here_nxt      = here_r;
    t_nxt         = t_r;
    data_nxt      = data_r;
    sched_nxt     = sched_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_waddr     = cnt_r;
    ram_wdata     = cnt_r;
    ram_raddr     = i_inc;
    case (state_r)
      rc4_pkg::ST_IDLE: begin
        if (accept) begin
          data_nxt = in_ch.data_in;
          if (need_sched) begin
            cnt_nxt = '0;
          end else begin
            i_nxt = i_inc;
          end
        end
      end
      rc4_pkg::ST_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_r;
        ram_wdata = cnt_r;
        cnt_nxt   = cnt_r + BW'(1);
        acc_nxt   = '0;
        kpos_nxt  = '0;
      end
      rc4_pkg::ST_K0: begin
        ram_raddr = cnt_r;
      end
      rc4_pkg::ST_K1: begin
        here_nxt  = ram_rdata;
        acc_nxt   = acc_sum;
        ram_raddr = acc_sum;
      end
      rc4_pkg::ST_K2: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_r;
        ram_wdata = ram_rdata;
      end
      rc4_pkg::ST_K3: begin
        ram_we    = 1'b1;
        ram_waddr = acc_r;
        ram_wdata = here_r;
        cnt_nxt   = cnt_r + BW'(1);
        kpos_nxt  = (kpos_inc >= key_len) ? '0 : kpos_inc[rc4_pkg::KPOS_W-1:0];
        if (last_cnt) begin
          i_nxt     = '0;
          j_nxt     = '0;
          sched_nxt = 1'b1;
        end
      end
      rc4_pkg::ST_G0: begin
        i_nxt     = i_inc;
        ram_raddr = i_inc;
      end
      rc4_pkg::ST_G1: begin
        si_nxt    = ram_rdata;
        j_nxt     = j_sum;
        ram_raddr = j_sum;
      end
      rc4_pkg::ST_G2: begin
        sj_nxt    = ram_rdata;
        ram_we    = 1'b1;
        ram_waddr = i_r;
        ram_wdata = ram_rdata;
        t_nxt     = t_sum;
        ram_raddr = t_sum;
      end
      rc4_pkg::ST_G3: begin
        ram_we    = 1'b1;
        ram_waddr = j_r;
        ram_wdata = si_r;
        ram_raddr = t_r;
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = data_r ^ ks_byte;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rc4_pkg::ST_IDLE;
      cnt_r       <= '0;
      acc_r       <= '0;
      kpos_r      <= '0;
      i_r         <= '0;
      j_r         <= '0;
      sched_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      acc_r       <= acc_nxt;
      kpos_r      <= kpos_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      sched_r     <= sched_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    si_r       <= si_nxt;
    sj_r       <= sj_nxt;
    here_r     <= here_nxt;
    t_r        <= t_nxt;
    data_r     <= data_nxt;
    out_data_r <= out_data_nxt;
  end

  rc4_ram #(
    .WIDTH (rc4_pkg::BYTE_W),
    .DEPTH (rc4_pkg::TABLE_SIZE)
  ) u_perm (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  a_sched_entry: assert property (@(posedge clk) disable iff (!rst_n)
    accept && need_sched |=> state_r == rc4_pkg::ST_FILL && cnt_r == '0)
    else $error("schedule not started on start beat");

  a_fast_entry: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !need_sched |=> state_r == rc4_pkg::ST_G1 && i_r == $past(i_inc))
    else $error("generator step not started");

  a_gen_sched: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rc4_pkg::ST_G0 || state_r == rc4_pkg::ST_G1) |-> sched_r)
    else $error("generator running before schedule");

  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == rc4_pkg::ST_G3)
    else $error("result beat not from final step");

  a_we_state: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == rc4_pkg::ST_FILL || state_r == rc4_pkg::ST_K2 ||
                state_r == rc4_pkg::ST_K3 || state_r == rc4_pkg::ST_G2 ||
                state_r == rc4_pkg::ST_G3))
    else $error("table write outside a write step");

endmodule

// ===== rtl/rc4_stream_cipher.sv =====
// Continuing byte: after accept, generator steps G1, G2, G3 (set by the dependent reads
// and the swap in the single permutation RAM); G3 loads the result register once the
// output is free, and no new byte is taken before that. Start byte (or first byte after
// reset): fill of all 256 entries, 256 key schedule steps K0-K3, then generator G0-G3.
// Reset (synchronous, rst_n low): indices cleared, no schedule seen, key 0, length 1;
// the permutation RAM is not cleared, it is always refilled before use.
module rc4_stream_cipher (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [rc4_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rc4_pkg::KEY_W-1:0]       cfg_data,
  rc4_in_if.sink                          in_ch,
  rc4_out_if.source                       out_ch
);

  logic [rc4_pkg::KEY_W-1:0] key_low_r, key_low_nxt;
  logic [rc4_pkg::KEY_W-1:0] key_high_r, key_high_nxt;
  logic [rc4_pkg::LEN_W-1:0] key_length_r, key_length_nxt;
  rc4_pkg::key_cfg_t         key_cfg;

  always_comb begin
    key_low_nxt    = key_low_r;
    key_high_nxt   = key_high_r;
    key_length_nxt = key_length_r;
    if (cfg_we) begin
      case (cfg_index)
        rc4_pkg::CFG_KEY_LOW:    key_low_nxt    = cfg_data;
        rc4_pkg::CFG_KEY_HIGH:   key_high_nxt   = cfg_data;
        rc4_pkg::CFG_KEY_LENGTH: key_length_nxt = cfg_data[rc4_pkg::LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_low_r    <= '0;
      key_high_r   <= '0;
      key_length_r <= rc4_pkg::LEN_W'(1);
    end else begin
      key_low_r    <= key_low_nxt;
      key_high_r   <= key_high_nxt;
      key_length_r <= key_length_nxt;
    end
  end

  assign key_cfg.key_low    = key_low_r;
  assign key_cfg.key_high   = key_high_r;
  assign key_cfg.key_length = key_length_r;

  rc4_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .key_cfg (key_cfg),
    .in_ch   (in_ch),
    .out_ch  (out_ch)
  );

endmodule
